>>> src/lcdseq_pkg.sv
package lcdseq_pkg;

    // Bus operation codes on the result channel.
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_WRITE  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_RESULT = 3'd4;

    // Request kinds on the input channel.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_BYTE  = 2'd2;

    // Command kinds passed from the front end to the sequencer.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_POLL   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // Expander bit that drives the LCD enable strobe.
    localparam logic [7:0] EN_BIT = 8'h04;

    // Index of the final step of the longest sequence.
    localparam logic [3:0] STEP_MAX = 4'd11;

    typedef struct packed {
        logic [1:0] kind;
        logic       fs;
        logic [7:0] addr_w;
        logic [7:0] b0;
        logic [7:0] b1;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic       busy;
        logic [3:0] step;
    } seq_status_t;

    // One bus operation of a command, chosen by the step index.
    function automatic beat_t step_out(cmd_t c, logic [3:0] step);
        beat_t      b;
        logic [3:0] s;
        b.op   = OP_STOP;
        b.data = 8'h00;
        b.last = 1'b0;
        s      = step;
        case (c.kind)
            CMD_WRITE:
            begin
                // Without a function set the second high-nibble pass is skipped.
                if (!c.fs && step >= 4'd5)
                begin
                    s = step + 4'd3;
                end
                case (s)
                    4'd0:
                    begin
                        b.op = OP_START;
                    end
                    4'd1:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.addr_w;
                    end
                    4'd2, 4'd5:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.b0;
                    end
                    4'd3, 4'd6:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.b0 | EN_BIT;
                    end
                    4'd4, 4'd7:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.b0 & ~EN_BIT;
                    end
                    4'd8:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.b1;
                    end
                    4'd9:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.b1 | EN_BIT;
                    end
                    4'd10:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.b1 & ~EN_BIT;
                    end
                    default:
                    begin
                        b.op   = OP_STOP;
                        b.last = 1'b1;
                    end
                endcase
            end
            CMD_POLL:
            begin
                case (s)
                    4'd0, 4'd5:
                    begin
                        b.op = OP_START;
                    end
                    4'd1:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.addr_w;
                    end
                    4'd2:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.b0;
                    end
                    4'd3:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.b1;
                    end
                    4'd4:
                    begin
                        b.op = OP_STOP;
                    end
                    4'd6:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.addr_w | 8'h01;
                    end
                    4'd7:
                    begin
                        b.op = OP_READ;
                    end
                    default:
                    begin
                        b.op   = OP_STOP;
                        b.last = 1'b1;
                    end
                endcase
            end
            CMD_FINISH:
            begin
                case (s)
                    4'd0:
                    begin
                        b.op = OP_START;
                    end
                    4'd1:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.addr_w;
                    end
                    4'd2:
                    begin
                        b.op   = OP_WRITE;
                        b.data = c.b0;
                    end
                    4'd3:
                    begin
                        b.op = OP_STOP;
                    end
                    default:
                    begin
                        b.op   = OP_RESULT;
                        b.data = c.b1;
                        b.last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                b.op   = OP_STOP;
                b.last = 1'b1;
            end
        endcase
        return b;
    endfunction

endpackage

>>> src/lcdseq_front.sv
module lcdseq_front
    import lcdseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic       reg_select,
    input  logic [7:0] data_byte,
    input  logic       cfg_write_en,
    input  logic [6:0] cfg_write_data,
    input  logic       full,
    output logic       push,
    output cmd_t       push_cmd
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] image_reg, image_next;
    logic [7:0] high_reg, high_next;
    logic [6:0] addr_reg;
    logic       accept;
    logic [7:0] v_high;
    logic [7:0] v_read;

    assign in_ready = !full;
    assign accept   = in_valid && !full;
    assign v_high   = {data_byte[7:4], 4'b1000} | {7'd0, reg_select};
    assign v_read   = reg_select ? 8'hFB : 8'hFA;

    // The front end tracks the port image and read phase at accept time, so
    // each command leaves here with every byte it needs already worked out.
    always_comb
    begin
        phase_next      = phase_reg;
        image_next      = image_reg;
        high_next       = high_reg;
        push            = 1'b0;
        push_cmd.kind   = CMD_WRITE;
        push_cmd.fs     = 1'b0;
        push_cmd.addr_w = {addr_reg, 1'b0};
        push_cmd.b0     = 8'h00;
        push_cmd.b1     = 8'h00;
        if (accept)
        begin
            case (kind)
                KIND_WRITE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_WRITE;
                        push_cmd.fs   = !reg_select && data_byte[5] && !data_byte[4];
                        push_cmd.b0   = v_high;
                        push_cmd.b1   = {data_byte[3:0], v_high[3:0]};
                        image_next    = {data_byte[3:0], v_high[3:0]};
                    end
                end
                KIND_READ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_POLL;
                        push_cmd.b0   = v_read;
                        push_cmd.b1   = v_read | EN_BIT;
                        image_next    = v_read | EN_BIT;
                        phase_next    = PH_HIGH;
                    end
                end
                KIND_BYTE:
                begin
                    if (phase_reg == PH_HIGH)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_POLL;
                        push_cmd.b0   = image_reg & ~EN_BIT;
                        push_cmd.b1   = image_reg | EN_BIT;
                        image_next    = image_reg | EN_BIT;
                        high_next     = {data_byte[7:4], 4'h0};
                        phase_next    = PH_LOW;
                    end
                    else if (phase_reg == PH_LOW)
                    begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_FINISH;
                        push_cmd.b0   = image_reg & ~EN_BIT;
                        push_cmd.b1   = {high_reg[7:4], data_byte[7:4]};
                        image_next    = image_reg & ~EN_BIT;
                        phase_next    = PH_IDLE;
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            image_reg <= 8'h00;
            high_reg  <= 8'h00;
            addr_reg  <= 7'd32;
        end
        else
        begin
            phase_reg <= phase_next;
            image_reg <= image_next;
            high_reg  <= high_next;
            if (cfg_write_en)
            begin
                addr_reg <= cfg_write_data;
            end
        end
    end

endmodule

>>> src/lcdseq_queue.sv
module lcdseq_queue
    import lcdseq_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  cmd_t                       push_cmd,
    output logic                       full,
    input  logic                       pop,
    output logic                       pop_valid,
    output cmd_t                       pop_cmd,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign count     = count_reg;
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/lcdseq_back.sv
module lcdseq_back
    import lcdseq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  bus_op,
    output logic [7:0]  bus_byte,
    output logic        last,
    output seq_status_t status
);

    cmd_t       cur_reg;
    logic       busy_reg;
    logic [3:0] step_reg;
    logic       out_valid_reg;
    beat_t      out_reg;
    beat_t      beat;
    logic       can_load;
    logic       advance;

    assign beat     = step_out(cur_reg, step_reg);
    assign can_load = !out_valid_reg || out_ready;
    assign advance  = busy_reg && can_load;
    // The next command is taken as the current one issues its final operation.
    assign pop      = q_valid && (!busy_reg || (advance && beat.last));

    assign out_valid   = out_valid_reg;
    assign bus_op      = out_reg.op;
    assign bus_byte    = out_reg.data;
    assign last        = out_reg.last;
    assign status.busy = busy_reg;
    assign status.step = step_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_cmd;
        end
        if (advance)
        begin
            out_reg <= beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                step_reg <= 4'd0;
            end
            else if (advance)
            begin
                step_reg <= step_reg + 4'd1;
                if (beat.last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> src/i2c_expander_lcd_nibble_sequencer_top.sv
// Character-LCD request sequencer for an HD44780-style display in 4-bit mode
// behind an 8-bit I2C port expander (P0 RS, P1 RW, P2 EN, P3 backlight,
// P4..P7 D4..D7). Each request is turned into byte-level bus operations that
// an I2C master carries out: start, write byte, read byte with no-ack, stop,
// and a final LCD result for a completed status read. A write request costs
// 9 operations, or 12 for a function-set command whose high nibble is sent
// twice. A read request and the first returned byte cost 9 each, and the
// second returned byte costs 5, the last being the busy flag and address
// counter. Requests that arrive out of phase are accepted and dropped. The
// back-end sequencer emits one operation per clock while the receiver is
// ready; the front end keeps accepting requests into a short command queue
// while earlier ones are being played out.
module i2c_expander_lcd_nibble_sequencer_top
    import lcdseq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic       reg_select,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] bus_op,
    output logic [7:0] bus_byte,
    output logic       last,
    input  logic       cfg_write_en,
    input  logic [6:0] cfg_write_data
);

    logic                             push;
    cmd_t                             push_cmd;
    logic                             full;
    logic                             pop;
    logic                             q_valid;
    cmd_t                             q_cmd;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
    seq_status_t                      seq_status;

    // The front end classifies each request against the read phase and
    // precomputes the expander bytes for its command.
    lcdseq_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .reg_select     (reg_select),
        .data_byte      (data_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .full           (full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // The queue decouples request intake from the bus sequencer.
    lcdseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd),
        .count     (q_count)
    );

    // The back end steps through each command and drives a registered
    // output stage, one bus operation per cycle while the receiver is ready.
    lcdseq_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bus_op    (bus_op),
        .bus_byte  (bus_byte),
        .last      (last),
        .status    (seq_status)
    );

`ifndef SYNTHESIS
    // The queue never holds more commands than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("command queue overfilled");

    // No command sequence runs past its twelfth operation.
    assert property (@(posedge clk) disable iff (!rst_n)
        seq_status.busy |-> seq_status.step <= STEP_MAX)
        else $error("sequencer step out of range");

    // An LCD result always closes its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bus_op == OP_RESULT |-> last)
        else $error("LCD result not marked last");

    // Start, read and stop operations carry no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (bus_op == OP_START || bus_op == OP_READ || bus_op == OP_STOP)
        |-> bus_byte == 8'h00)
        else $error("control operation carries a byte");
`endif

endmodule

>>> dv/lcd_bus_op_checker.sv
module lcd_bus_op_checker
    import lcdseq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] kind,
    input  logic       reg_select,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] bus_op,
    input  logic [7:0] bus_byte,
    input  logic       last,
    input  logic       cfg_write_en,
    input  logic [6:0] cfg_write_data,
    output int         mismatches,
    output int         pending,
    output int         ops_checked
);

    localparam logic [6:0] ADDR_AT_RESET = 7'd32;
    localparam logic [7:0] RS_BIT        = 8'h01;
    localparam logic [7:0] RW_BIT        = 8'h02;
    localparam logic [7:0] BACKLIGHT_BIT = 8'h08;
    localparam logic [7:0] DATA_LINES    = 8'hF0;

    typedef enum logic [1:0] {PHASE_IDLE, PHASE_HIGH, PHASE_LOW} status_phase_t;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        logic       is_last;
    } bus_step_t;

    bus_step_t     expected_ops[$];
    logic [6:0]    expander_addr;
    status_phase_t phase;
    logic [7:0]    port_byte;
    logic [7:0]    busy_high;

    task automatic queue_op(input logic [2:0] op, input logic [7:0] data);
        bus_step_t s;
        s.op      = op;
        s.data    = data;
        s.is_last = 1'b0;
        expected_ops.push_back(s);
    endtask

    // Every byte written to the expander becomes the new port image.
    task automatic queue_port(input logic [7:0] value);
        port_byte = value;
        queue_op(OP_WRITE, value);
    endtask

    task automatic queue_strobe(input logic [7:0] value);
        queue_port(value);
        queue_port(value | EN_BIT);
        queue_port(value & ~EN_BIT);
    endtask

    task automatic queue_read_frame();
        queue_op(OP_START, 8'h00);
        queue_op(OP_WRITE, {expander_addr, 1'b1});
        queue_op(OP_READ, 8'h00);
        queue_op(OP_STOP, 8'h00);
    endtask

    task automatic expand_request(input logic [1:0] k, input logic rs, input logic [7:0] d);
        int         start_size;
        logic [7:0] nibble;
        bus_step_t  tail;
        start_size = expected_ops.size();
        if (k == KIND_WRITE && phase == PHASE_IDLE)
        begin
            nibble = BACKLIGHT_BIT | (rs ? RS_BIT : 8'h00) | (d & DATA_LINES);
            queue_op(OP_START, 8'h00);
            queue_op(OP_WRITE, {expander_addr, 1'b0});
            queue_strobe(nibble);
            // A function-set instruction sends its high nibble a second time.
            if ((nibble & 8'h31) == 8'h20)
            begin
                queue_strobe(nibble);
            end
            nibble = {d[3:0], nibble[3:0]};
            queue_strobe(nibble);
            queue_op(OP_STOP, 8'h00);
        end
        else if (k == KIND_READ && phase == PHASE_IDLE)
        begin
            nibble = DATA_LINES | BACKLIGHT_BIT | RW_BIT | (rs ? RS_BIT : 8'h00);
            queue_op(OP_START, 8'h00);
            queue_op(OP_WRITE, {expander_addr, 1'b0});
            queue_port(nibble);
            queue_port(nibble | EN_BIT);
            queue_op(OP_STOP, 8'h00);
            queue_read_frame();
            phase = PHASE_HIGH;
        end
        else if (k == KIND_BYTE && phase == PHASE_HIGH)
        begin
            busy_high = d & DATA_LINES;
            queue_op(OP_START, 8'h00);
            queue_op(OP_WRITE, {expander_addr, 1'b0});
            queue_port(port_byte & ~EN_BIT);
            queue_port(port_byte | EN_BIT);
            queue_op(OP_STOP, 8'h00);
            queue_read_frame();
            phase = PHASE_LOW;
        end
        else if (k == KIND_BYTE && phase == PHASE_LOW)
        begin
            queue_op(OP_START, 8'h00);
            queue_op(OP_WRITE, {expander_addr, 1'b0});
            queue_port(port_byte & ~EN_BIT);
            queue_op(OP_STOP, 8'h00);
            queue_op(OP_RESULT, busy_high | {4'h0, d[7:4]});
            phase = PHASE_IDLE;
        end
        if (expected_ops.size() > start_size)
        begin
            tail = expected_ops.pop_back();
            tail.is_last = 1'b1;
            expected_ops.push_back(tail);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        bus_step_t want;
        int        errs;
        errs = 0;
        if (!rst_n)
        begin
            expected_ops.delete();
            expander_addr = ADDR_AT_RESET;
            phase         = PHASE_IDLE;
            port_byte     = 8'h00;
            busy_high     = 8'h00;
            mismatches  <= 0;
            pending     <= 0;
            ops_checked <= 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                expander_addr = cfg_write_data;
            end
            if (in_valid && in_ready)
            begin
                expand_request(kind, reg_select, data_byte);
            end
            if (out_valid && out_ready)
            begin
                if (expected_ops.size() == 0)
                begin
                    $display("%0t: unexpected bus op %0d byte 0x%02h last %0b",
                             $time, bus_op, bus_byte, last);
                    errs++;
                end
                else
                begin
                    want = expected_ops.pop_front();
                    if (bus_op !== want.op)
                    begin
                        $display("%0t: bus_op expected %0d, got %0d", $time, want.op, bus_op);
                        errs++;
                    end
                    if (bus_byte !== want.data)
                    begin
                        $display("%0t: bus_byte expected 0x%02h, got 0x%02h",
                                 $time, want.data, bus_byte);
                        errs++;
                    end
                    if (last !== want.is_last)
                    begin
                        $display("%0t: last expected %0b, got %0b", $time, want.is_last, last);
                        errs++;
                    end
                    ops_checked <= ops_checked + 1;
                end
            end
            mismatches <= mismatches + errs;
            pending    <= expected_ops.size();
        end
    end

endmodule

>>> dv/testbench.sv
module testbench;

    import lcdseq_pkg::*;

    // The package has no name for the fourth request kind; the block must drop it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Cycles allowed after the last expected bus operation before the block
    // counts as idle. A dropped request never enters the command queue, and
    // a full queue holds at most two commands of twelve steps.
    localparam int DRAIN_CYCLES = 40;

    // Hard stop for the whole run.
    localparam int CYCLE_LIMIT = 200000;

    // Length of the receiver hold-off that backs the block up.
    localparam int HOLD_OFF_CYCLES = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] kind = 2'd0;
    logic       reg_select = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] bus_op;
    logic [7:0] bus_byte;
    logic       last;
    logic       cfg_write_en = 1'b0;
    logic [6:0] cfg_write_data = 7'd0;

    int mismatches;
    int pending;
    int ops_checked;

    int cycle_count = 0;
    int requests_accepted = 0;
    int useful_items = 0;
    int addresses_used = 1;

    // Shared knobs. steady and hold_off_go are written by the stimulus with
    // nonblocking assignments so the receiver never sees them mid-step.
    logic steady = 1'b0;
    logic hold_off_go = 1'b0;
    logic hold_off_done = 1'b0;

    always #5 clk = ~clk;

    i2c_expander_lcd_nibble_sequencer_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .reg_select     (reg_select),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bus_op         (bus_op),
        .bus_byte       (bus_byte),
        .last           (last),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // The checker watches both channels and the register port, predicts the
    // bus operations of every accepted request and compares them in order.
    lcd_bus_op_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .reg_select     (reg_select),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .bus_op         (bus_op),
        .bus_byte       (bus_byte),
        .last           (last),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .ops_checked    (ops_checked)
    );

    // Watchdog. A hung handshake anywhere ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d bus operations outstanding",
                     cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver side. It drops ready in about a third of the cycles, except
    // during the steady stretch. Once the stimulus asks for it, ready stays
    // low for a long hold-off so the command queue fills and the block stops
    // taking requests.
    initial
    begin : receiver
        int held;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !hold_off_done)
            begin
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_OFF_CYCLES; held++)
                begin
                    @(posedge clk);
                end
                hold_off_done = 1'b1;
            end
            out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 35);
        end
    end

    // Offer one request and wait for it to be taken. Before the request the
    // sender may idle at random, except in the steady stretch. After acceptance valid is left as it
    // is, so the next call either drops it or keeps it high with a new
    // payload, never both in the same step.
    task automatic offer_request(input logic [1:0] k, input logic rs, input logic [7:0] d);
        while (!steady && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        reg_select <= rs;
        data_byte  <= d;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        requests_accepted++;
    endtask

    // The expander address may only change while the block is idle: every
    // predicted operation has been seen, and the drain wait has passed
    // after it.
    task automatic change_address(input logic [6:0] addr);
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= addr;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        addresses_used++;
    endtask

    // A request that arrives in the wrong phase of a status read.
    task automatic misplaced_request();
        int pick;
        pick = $urandom_range(2);
        offer_request(pick == 0 ? KIND_WRITE : (pick == 1 ? KIND_READ : KIND_UNUSED),
                      1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    // One random unit of traffic. Most of it is complete LCD writes and
    // complete status reads, the latter sometimes interrupted by requests
    // that the block must drop. The rest is stray returned bytes and the
    // unused kind while no read is open.
    task automatic random_sequence();
        int         pick;
        logic [7:0] d;
        pick = $urandom_range(99);
        d    = 8'($urandom_range(255));
        if (pick < 45)
        begin
            if ($urandom_range(3) == 0)
            begin
                // Force the function-set pattern: RS low, bit 5 set, bit 4 clear.
                offer_request(KIND_WRITE, 1'b0, {d[7:6], 2'b10, d[3:0]});
            end
            else
            begin
                offer_request(KIND_WRITE, 1'($urandom_range(1)), d);
            end
            useful_items++;
        end
        else if (pick < 85)
        begin
            offer_request(KIND_READ, 1'($urandom_range(1)), d);
            if ($urandom_range(4) == 0)
            begin
                misplaced_request();
            end
            offer_request(KIND_BYTE, 1'($urandom_range(1)), 8'($urandom_range(255)));
            if ($urandom_range(4) == 0)
            begin
                misplaced_request();
            end
            offer_request(KIND_BYTE, 1'($urandom_range(1)), 8'($urandom_range(255)));
            useful_items += 3;
        end
        else
        begin
            offer_request($urandom_range(1) ? KIND_BYTE : KIND_UNUSED,
                          1'($urandom_range(1)), d);
        end
    endtask

    initial
    begin : stimulus
        int blk;
        int flood;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset address. Writes with all-zero and
        // all-one data, the function-set pattern and two near misses (RS
        // high, bit 4 set), a stray returned byte and the unused kind while
        // idle, then status reads with requests dropped in both read phases
        // and returned bytes at their extremes.
        offer_request(KIND_WRITE, 1'b0, 8'h00);
        offer_request(KIND_WRITE, 1'b1, 8'hFF);
        offer_request(KIND_WRITE, 1'b0, 8'h28);
        offer_request(KIND_WRITE, 1'b0, 8'hEF);
        offer_request(KIND_WRITE, 1'b1, 8'h2C);
        offer_request(KIND_WRITE, 1'b0, 8'h38);
        offer_request(KIND_BYTE, 1'b0, 8'hAB);
        offer_request(KIND_UNUSED, 1'b1, 8'hFF);
        offer_request(KIND_READ, 1'b0, 8'h00);
        offer_request(KIND_WRITE, 1'b0, 8'h28);
        offer_request(KIND_READ, 1'b1, 8'h55);
        offer_request(KIND_BYTE, 1'b1, 8'hFF);
        offer_request(KIND_UNUSED, 1'b0, 8'h00);
        offer_request(KIND_READ, 1'b0, 8'hFF);
        offer_request(KIND_BYTE, 1'b0, 8'h00);
        offer_request(KIND_READ, 1'b1, 8'hFF);
        offer_request(KIND_BYTE, 1'b0, 8'h00);
        offer_request(KIND_BYTE, 1'b1, 8'hFF);

        // Both address extremes.
        change_address(7'd0);
        offer_request(KIND_WRITE, 1'b1, 8'h5A);
        offer_request(KIND_READ, 1'b0, 8'h00);
        offer_request(KIND_BYTE, 1'b0, 8'h80);
        offer_request(KIND_BYTE, 1'b0, 8'h7F);
        change_address(7'd127);
        offer_request(KIND_WRITE, 1'b0, 8'hA5);
        offer_request(KIND_READ, 1'b1, 8'h00);
        offer_request(KIND_BYTE, 1'b1, 8'h3C);
        offer_request(KIND_BYTE, 1'b0, 8'hC3);

        // Random part in four blocks, each at a random address. The second
        // block runs with no idling on either side. The third opens with a
        // burst of writes against a receiver that holds off for a long time.
        for (blk = 0; blk < 4; blk++)
        begin
            change_address(7'($urandom_range(127)));
            steady <= (blk == 1);
            if (blk == 2)
            begin
                hold_off_go <= 1'b1;
                for (flood = 0; flood < 12; flood++)
                begin
                    offer_request(KIND_WRITE, 1'($urandom_range(1)),
                                  8'($urandom_range(255)));
                    useful_items++;
                end
            end
            while (useful_items < 30 * (blk + 1))
            begin
                random_sequence();
            end
        end
        in_valid <= 1'b0;

        // Let every predicted operation come out, then give a dropped
        // request time to surface anything it should not.
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d accepted requests (%0d in complete sequences) at %0d addresses,",
                 requests_accepted, useful_items, addresses_used);
        $display("%0d bus operations compared, including a %0d-cycle receiver hold-off.",
                 ops_checked, HOLD_OFF_CYCLES);
        if (pending != 0)
        begin
            $display("%0d expected bus operations never arrived", pending);
        end
        if (mismatches == 0 && pending == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
